FILE: rtl/slfd_pkg.sv
// Shared constants and control/status types for the scan line framer.
`timescale 1ns / 1ps

package slfd_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUP_WINDOW   = 2'd1;

    localparam logic [15:0] LINE_TIMEOUT_RST = 16'd100;
    localparam logic [15:0] DUP_WINDOW_RST   = 16'd1000;

    // Sequencer requests to the clock and age unit.
    typedef struct packed {
        logic tick;     // advance the millisecond clock
        logic rx_byte;  // stamp the last receive time
        logic emit;     // stamp the last emit time
        logic sel_age;  // 1: compare age of last emission, 0: idle time
    } slfd_clk_ctl_t;

    // Results from the clock and age unit.
    typedef struct packed {
        logic [31:0] now_ms;
        logic        timed_out;  // idle time exceeds line timeout
        logic        in_window;  // age of last emission below dup window
    } slfd_clk_sts_t;

endpackage

FILE: rtl/slfd_ram.sv
// Generic simple dual-port RAM with registered, enabled read.
`timescale 1ns / 1ps

module slfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/slfd_clock.sv
// Millisecond clock, time stamps, config registers and shared age compare unit.
`timescale 1ns / 1ps

module slfd_clock
    import slfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  slfd_clk_ctl_t         ctl,
    output slfd_clk_sts_t         sts
);

    logic [31:0] now_reg, now_next;
    logic [31:0] last_rx_reg, last_rx_next;
    logic [31:0] emit_time_reg, emit_time_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [15:0] window_reg, window_next;
    logic [31:0] operand;
    logic [31:0] diff;

    always_comb begin
        now_next       = now_reg;
        last_rx_next   = last_rx_reg;
        emit_time_next = emit_time_reg;
        timeout_next   = timeout_reg;
        window_next    = window_reg;
        if (ctl.tick) begin
            now_next = now_reg + 32'd1;
        end
        if (ctl.rx_byte) begin
            last_rx_next = now_reg;
        end
        if (ctl.emit) begin
            emit_time_next = now_reg;
        end
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_LINE_TIMEOUT: timeout_next = cfg_wdata;
                REG_DUP_WINDOW:   window_next  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg       <= '0;
            last_rx_reg   <= '0;
            emit_time_reg <= '0;
            timeout_reg   <= LINE_TIMEOUT_RST;
            window_reg    <= DUP_WINDOW_RST;
        end else begin
            now_reg       <= now_next;
            last_rx_reg   <= last_rx_next;
            emit_time_reg <= emit_time_next;
            timeout_reg   <= timeout_next;
            window_reg    <= window_next;
        end
    end

    // One subtractor serves both the idle timeout and the duplicate age.
    assign operand       = ctl.sel_age ? emit_time_reg : last_rx_reg;
    assign diff          = now_reg - operand;
    assign sts.now_ms    = now_reg;
    assign sts.timed_out = diff > {16'd0, timeout_reg};
    assign sts.in_window = diff < {16'd0, window_reg};

endmodule

FILE: rtl/scan_line_framer_dedupe_unit.sv
// Top level: line assembly, duplicate compare and emit sequencer.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-----------------
//  input    | s_action, s_rx_byte                    | s_valid / s_ready
//  result   | m_line_byte, m_line_last, m_line_time  | m_valid / m_ready
//  config   | cfg_index, cfg_wdata                   | cfg_wr_en
//
// A plain byte is taken in the idle state; a tick advances the clock, then tests the timeout.
// A line end passes from the accept through the compare state when the lengths match,
// then the decide state and the emit state, one byte at a time through the single read
// port of each line RAM, for lines of up to MAX_LINE bytes. Stalls on m_ready stretch
// the emit phase.
// s_ready is low from a tick or a non-empty line end until the sequencer returns to idle.
// Reset (synchronous, aresetn low) clears counts and clocks and restores config to its reset values.
`timescale 1ns / 1ps

module scan_line_framer_dedupe_unit
    import slfd_pkg::*;
#(
    parameter int MAX_LINE = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [7:0]            s_rx_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_line_byte,
    output logic                  m_line_last,
    output logic [31:0]           m_line_time,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int CW = $clog2(MAX_LINE + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_LINE);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TICK   = 3'd1;
    localparam logic [2:0] ST_CMP    = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] prev_count_reg, prev_count_next;
    logic [CW-1:0] issue_idx_reg, issue_idx_next;
    logic [CW-1:0] out_idx_reg, out_idx_next;
    logic          pend_reg, pend_next;
    logic          same_reg, same_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;
    logic [31:0]   out_time_reg, out_time_next;

    slfd_clk_ctl_t clk_ctl;
    slfd_clk_sts_t clk_sts;

    logic          line_we, line_re, prev_we, prev_re;
    logic [7:0]    line_rd, prev_rd;
    logic          accept, is_term, can_load, issue, out_last;

    slfd_clock u_clock (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ctl       (clk_ctl),
        .sts       (clk_sts)
    );

    slfd_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_rx_byte),
        .re    (line_re),
        .raddr (issue_idx_reg[AW-1:0]),
        .rdata (line_rd)
    );

    slfd_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (out_idx_reg[AW-1:0]),
        .wdata (line_rd),
        .re    (prev_re),
        .raddr (issue_idx_reg[AW-1:0]),
        .rdata (prev_rd)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_term  = (s_rx_byte == CH_CR) || (s_rx_byte == CH_LF);
    assign can_load = pend_reg && (!m_valid_reg || m_ready);
    assign out_last = (out_idx_reg == count_reg - CW'(1));

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        prev_count_next = prev_count_reg;
        issue_idx_next  = issue_idx_reg;
        out_idx_next    = out_idx_reg;
        pend_next       = pend_reg;
        same_next       = same_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_time_next   = out_time_reg;
        clk_ctl         = '0;
        line_we         = 1'b0;
        line_re         = 1'b0;
        prev_we         = 1'b0;
        prev_re         = 1'b0;
        issue           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action) begin
                        clk_ctl.tick = 1'b1;
                        state_next   = ST_TICK;
                    end else begin
                        clk_ctl.rx_byte = 1'b1;
                        if (is_term) begin
                            if (count_reg != '0) begin
                                issue_idx_next = '0;
                                pend_next      = 1'b0;
                                same_next      = (count_reg == prev_count_reg);
                                state_next     = (count_reg == prev_count_reg) ?
                                                 ST_CMP : ST_DECIDE;
                            end
                        end else if (count_reg == FULL) begin
                            // drop the overfull line and this byte
                            count_next = '0;
                        end else begin
                            line_we    = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end

            ST_TICK: begin
                if (count_reg != '0 && clk_sts.timed_out) begin
                    issue_idx_next = '0;
                    pend_next      = 1'b0;
                    same_next      = (count_reg == prev_count_reg);
                    state_next     = (count_reg == prev_count_reg) ? ST_CMP : ST_DECIDE;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_CMP: begin
                // compare the byte read last cycle while issuing the next read
                if (pend_reg && (line_rd != prev_rd)) begin
                    same_next = 1'b0;
                end
                issue     = (issue_idx_reg != count_reg);
                pend_next = issue;
                if (issue) begin
                    line_re        = 1'b1;
                    prev_re        = 1'b1;
                    issue_idx_next = issue_idx_reg + CW'(1);
                end else begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                clk_ctl.sel_age = 1'b1;
                if (same_reg && clk_sts.in_window) begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end else begin
                    clk_ctl.emit    = 1'b1;
                    prev_count_next = count_reg;
                    issue_idx_next  = '0;
                    out_idx_next    = '0;
                    pend_next       = 1'b0;
                    state_next      = ST_EMIT;
                end
            end

            ST_EMIT: begin
                // hold the read data until the output register frees up
                issue = (issue_idx_reg != count_reg) && (!pend_reg || can_load);
                if (issue) begin
                    line_re        = 1'b1;
                    issue_idx_next = issue_idx_reg + CW'(1);
                end
                pend_next = issue || (pend_reg && !can_load);
                if (can_load) begin
                    prev_we       = 1'b1;
                    m_valid_next  = 1'b1;
                    out_byte_next = line_rd;
                    out_last_next = out_last;
                    out_time_next = clk_sts.now_ms;
                    out_idx_next  = out_idx_reg + CW'(1);
                    if (out_last) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            prev_count_reg <= '0;
            issue_idx_reg  <= '0;
            out_idx_reg    <= '0;
            pend_reg       <= 1'b0;
            same_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            prev_count_reg <= prev_count_next;
            issue_idx_reg  <= issue_idx_next;
            out_idx_reg    <= out_idx_next;
            pend_reg       <= pend_next;
            same_reg       <= same_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_time_reg <= out_time_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_line_byte = out_byte_reg;
    assign m_line_last = out_last_reg;
    assign m_line_time = out_time_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("line count beyond capacity");

    a_emit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (out_idx_reg <= issue_idx_reg) &&
                                   (issue_idx_reg <= count_reg))
        else $error("emit indices out of order");

    a_pend_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (issue_idx_reg != '0))
        else $error("pending read without an issued address");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && $past(state_reg) == ST_EMIT) |-> (count_reg == '0))
        else $error("line not cleared after emission");
`endif

endmodule

FILE: tb/scan_line_framer_dedupe_unit_tb.sv
// Self-checking testbench for the scan line framer with repeat-line suppression.
`timescale 1ns / 1ps

module scan_line_framer_dedupe_unit_tb;
    import slfd_pkg::*;

    localparam int MAX_LINE       = 64;
    localparam int SETTLE_CYCLES  = 2 * MAX_LINE + 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 8;

    // Indexes past the two registers; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        bit          action;
        logic [7:0]  data;
        bit          hold;   // present only once every pending line beat has arrived
        int unsigned gap;
    } scan_item_t;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [31:0] stamp;
    } line_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_action  = 1'b0;
    logic [7:0]            s_rx_byte = 8'h00;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [7:0]            m_line_byte;
    logic                  m_line_last;
    logic [31:0]           m_line_time;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    scan_line_framer_dedupe_unit #(
        .MAX_LINE(MAX_LINE)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_line_byte(m_line_byte),
        .m_line_last(m_line_last),
        .m_line_time(m_line_time),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    scan_item_t  feed_q[$];
    line_beat_t  line_exp_q[$];
    logic [7:0]  prior_line[$];
    int unsigned queued_total = 0;
    int unsigned err_cnt      = 0;
    int unsigned idle_cycles  = 0;
    int unsigned tx_wait      = 0;
    int unsigned rx_hold      = 0;
    bit          tx_burst     = 1'b0;
    bit          rx_burst     = 1'b0;
    bit          in_taken     = 1'b0;
    bit          out_taken    = 1'b0;

    // Predictor state
    logic [7:0]  asm_buf[MAX_LINE];
    logic [6:0]  asm_cnt;
    logic [7:0]  sent_buf[MAX_LINE];
    logic [6:0]  sent_cnt;
    logic [31:0] sent_time;
    logic [31:0] rx_stamp;
    logic [31:0] ms_clock;
    logic [15:0] cfg_timeout;
    logic [15:0] cfg_window;

    function automatic int unsigned pause_len(input bit burst);
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [7:0] pick_payload();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == CH_CR || v == CH_LF);
        return v;
    endfunction

    // Emit the assembled line unless it repeats the last one inside the window.
    task automatic flush_line();
        bit         same;
        line_beat_t beat;
        same = (asm_cnt == sent_cnt);
        if (same) begin
            for (int k = 0; k < asm_cnt; k++) begin
                if (asm_buf[k] != sent_buf[k]) same = 1'b0;
            end
        end
        if (!(same && (ms_clock - sent_time) < {16'd0, cfg_window})) begin
            for (int k = 0; k < asm_cnt; k++) begin
                sent_buf[k] = asm_buf[k];
                beat.data   = asm_buf[k];
                beat.last   = (k == asm_cnt - 1);
                beat.stamp  = ms_clock;
                line_exp_q.push_back(beat);
            end
            sent_cnt  = asm_cnt;
            sent_time = ms_clock;
        end
        asm_cnt = '0;
    endtask

    task automatic frame_step(input bit act, input logic [7:0] ch);
        if (act) begin
            ms_clock = ms_clock + 32'd1;
            if (asm_cnt != 0 && (ms_clock - rx_stamp) > {16'd0, cfg_timeout}) flush_line();
        end else begin
            rx_stamp = ms_clock;
            if (ch == CH_CR || ch == CH_LF) begin
                if (asm_cnt != 0) flush_line();
            end else if (asm_cnt >= MAX_LINE) begin
                // drop the full line along with this byte
                asm_cnt = '0;
            end else begin
                asm_buf[asm_cnt] = ch;
                asm_cnt          = asm_cnt + 7'd1;
            end
        end
    endtask

    task automatic check_beat();
        line_beat_t want;
        if (line_exp_q.size() == 0) begin
            $display("%0t: unexpected line beat: byte %h last %b time %0d",
                     $time, m_line_byte, m_line_last, m_line_time);
            err_cnt++;
        end else begin
            want = line_exp_q.pop_front();
            if (m_line_byte !== want.data || m_line_last !== want.last ||
                m_line_time !== want.stamp) begin
                $display("%0t: line beat mismatch: expected byte %h last %b time %0d, got byte %h last %b time %0d",
                         $time, want.data, want.last, want.stamp,
                         m_line_byte, m_line_last, m_line_time);
                err_cnt++;
            end
        end
    endtask

    // Predict, check and watch for a hang on the rising edge.
    always @(posedge aclk) begin
        in_taken  <= s_valid && s_ready;
        out_taken <= m_valid && m_ready;
        if (!aresetn) begin
            asm_cnt     = '0;
            sent_cnt    = '0;
            sent_time   = '0;
            rx_stamp    = '0;
            ms_clock    = '0;
            cfg_timeout = LINE_TIMEOUT_RST;
            cfg_window  = DUP_WINDOW_RST;
            idle_cycles = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_LINE_TIMEOUT) cfg_timeout = cfg_wdata;
                else if (cfg_index == REG_DUP_WINDOW) cfg_window = cfg_wdata;
            end
            if (s_valid && s_ready) frame_step(s_action, s_rx_byte);
            if (m_valid && m_ready) check_beat();
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("scan_line_framer_dedupe_unit_tb failed");
                $finish;
            end
        end
    end

    // Input driver: hold each transaction until taken, then idle for its gap.
    always @(negedge aclk) begin
        scan_item_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (feed_q.size() != 0 && !(feed_q[0].hold && line_exp_q.size() != 0) &&
                tx_wait >= feed_q[0].gap) begin
                cur = feed_q.pop_front();
                s_valid   <= 1'b1;
                s_action  <= cur.action;
                s_rx_byte <= cur.data;
                tx_wait = 0;
            end else begin
                s_valid <= 1'b0;
                if (feed_q.size() != 0 && tx_wait < feed_q[0].gap) tx_wait++;
            end
        end
    end

    // Result sink: stall a random number of cycles after each transaction, and at random while no result waits.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (out_taken) rx_hold = pause_len(rx_burst);
            else if (!m_valid && rx_hold == 0 && $urandom_range(0, 15) == 0)
                rx_hold = pause_len(rx_burst);
            if (rx_hold != 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_item(input bit act, input logic [7:0] data, input bit hold);
        scan_item_t it;
        it.action = act;
        it.data   = data;
        it.hold   = hold;
        it.gap    = pause_len(tx_burst);
        feed_q.push_back(it);
        queued_total++;
    endtask

    task automatic push_byte(input logic [7:0] data);
        push_item(1'b0, data, 1'b0);
    endtask

    task automatic push_ticks(input int unsigned n);
        for (int i = 0; i < n; i++) push_item(1'b1, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (feed_q.size() != 0 || s_valid || line_exp_q.size() != 0);
    endtask

    task automatic set_config(input int unsigned tmo, input int unsigned win);
        wait_drained();
        // let a suppressed compare finish before touching the registers
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_LINE_TIMEOUT, 16'(tmo));
        write_reg(REG_DUP_WINDOW, 16'(win));
    endtask

    // One line: payload bytes, a few ticks inside, ended by CR, LF or timeout.
    task automatic gen_line(input int unsigned len, input int unsigned tmo, input bit fresh);
        logic [7:0]  body[$];
        int unsigned pick;
        if (!fresh && prior_line.size() != 0 && $urandom_range(0, 9) < 3) begin
            body = prior_line;
        end else begin
            for (int i = 0; i < len; i++) body.push_back(pick_payload());
        end
        foreach (body[i]) begin
            push_byte(body[i]);
            if (tmo != 0 && $urandom_range(0, 6) == 0)
                push_ticks($urandom_range(1, (tmo < 2) ? tmo : 2));
        end
        pick = $urandom_range(0, 2);
        if (pick == 2 && (tmo <= 8 || (tmo <= 120 && $urandom_range(0, 3) == 0)))
            push_ticks(tmo + 1);
        else
            push_byte((pick == 0) ? CH_CR : CH_LF);
        prior_line = body;
        push_ticks($urandom_range(0, 3));
    endtask

    // Fill past the buffer limit; the first extra byte is dropped and the rest start over from empty.
    task automatic gen_overflow();
        for (int i = 0; i < MAX_LINE; i++) push_byte(pick_payload());
        for (int i = 0; i < $urandom_range(1, 3); i++) push_byte(pick_payload());
        push_byte(CH_CR);
    endtask

    task automatic gen_sequence(input int unsigned tmo);
        logic [7:0] v;
        if ($urandom_range(0, 6) == 0) tx_burst = !tx_burst;
        if ($urandom_range(0, 6) == 0) rx_burst = !rx_burst;
        if ($urandom_range(0, 9) < 2) begin
            for (int i = 0; i < $urandom_range(1, 4); i++) begin
                v = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 1) ? CH_CR : CH_LF;
                push_item(1'($urandom_range(0, 1)), v, 1'b0);
            end
        end else begin
            gen_line($urandom_range(1, 8), tmo, 1'b0);
        end
    endtask

    initial begin
        int unsigned tmo_set[6];
        int unsigned win_set[6];
        int unsigned phase_base;

        tmo_set = '{3, 0, 65535, 100, 1, 0};
        win_set = '{5, 65535, 0, 1000, 2, 0};
        tmo_set[5] = $urandom_range(0, 65535);
        win_set[5] = $urandom_range(0, 65535);

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: a repeat inside the window is dropped, empty ends do nothing.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_CR);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_LF);
        push_item(1'b0, CH_LF, 1'b1);
        push_byte(CH_CR);
        push_byte(8'h80);
        push_byte(8'h7F);
        push_byte(8'h55);
        push_byte(8'hAA);
        push_byte(CH_LF);

        // Zero timeout flushes on the first tick; zero window never drops a repeat.
        set_config(0, 0);
        push_byte(8'h31);
        push_ticks(1);
        push_byte(8'h31);
        push_ticks(1);
        push_byte(8'h00);
        push_byte(CH_CR);

        // Flush only once the idle time exceeds the timeout, on the third tick.
        set_config(2, 65535);
        push_byte(8'h31);
        push_ticks(3);
        push_byte(8'h31);
        push_byte(CH_CR);
        push_byte(8'h32);
        push_byte(CH_CR);

        for (int p = 0; p < 6; p++) begin
            set_config(tmo_set[p], win_set[p]);
            if (p == 3) begin
                write_reg(REG_SPARE_2, 16'($urandom_range(0, 65535)));
                write_reg(REG_SPARE_3, 16'($urandom_range(0, 65535)));
            end
            phase_base = queued_total;
            if (p == 1) gen_overflow();
            if (p == 2) gen_line(MAX_LINE, tmo_set[p], 1'b1);
            while (queued_total - phase_base < PHASE_ITEMS) gen_sequence(tmo_set[p]);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("scan_line_framer_dedupe_unit_tb passed");
        end else begin
            $display("scan_line_framer_dedupe_unit_tb failed");
        end
        $finish;
    end

endmodule
